// File: rtl/si_window_tracker_core_defines.svh
// assertion macros shared by the si window tracker rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef SI_WINDOW_TRACKER_CORE_DEFINES_SVH
`define SI_WINDOW_TRACKER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SWT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/swt_pkg.sv
// types and constants for the si window tracker
// no dependencies
`timescale 1ns / 1ps

package swt_pkg;

  localparam int MASK_W     = 4;
  localparam int FRAME_W    = 10;
  localparam int SLOT_W     = 8;
  localparam int WLEN_W     = 12;
  localparam int NSLOT_W    = 8;
  localparam int MCNT_W     = 3;
  localparam int PERIOD_W   = 10;
  localparam int PERIOD_CNT = 4;
  localparam int ABS_W      = NSLOT_W + FRAME_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // shared divider: dividend and divisor widths
  localparam int DIV_DW = 14;
  localparam int DIV_SW = 11;
  localparam int DIV_CW = $clog2(DIV_DW);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MSG_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD0    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD1    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD2    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD3    = 3'd6;

  // register reset values
  localparam logic [WLEN_W-1:0]   WINDOW_LEN_RST = 12'd20;
  localparam logic [NSLOT_W-1:0]  SLOTS_RST      = 8'd10;
  localparam logic [MCNT_W-1:0]   MSG_COUNT_RST  = 3'd0;
  localparam logic [PERIOD_W-1:0] PERIOD_RST     = 10'd8;

  // a zero period counts as the full frame number range
  localparam logic [DIV_SW-1:0]   PERIOD_ZERO_AS = 11'd1024;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_SW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_DW-1:0] quot;
    logic [DIV_SW-1:0] rem;
  } div_rsp_t;

endpackage

// File: rtl/swt_tick_if.sv
// slot tick channel: frame number and slot within the frame
// depends on swt_pkg
`timescale 1ns / 1ps

interface swt_tick_if import swt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_number;
  logic [SLOT_W-1:0]  slot_in_frame;

  modport source (output valid, output frame_number, output slot_in_frame, input ready);
  modport sink (input valid, input frame_number, input slot_in_frame, output ready);
endinterface

// File: rtl/swt_mask_if.sv
// result channel: open, start and end masks for one tick
// depends on swt_pkg
`timescale 1ns / 1ps

interface swt_mask_if import swt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] window_open_mask;
  logic [MASK_W-1:0] window_start_mask;
  logic [MASK_W-1:0] window_end_mask;

  modport source (output valid, output window_open_mask, output window_start_mask,
                  output window_end_mask, input ready);
  modport sink (input valid, input window_open_mask, input window_start_mask,
                input window_end_mask, output ready);
endinterface

// File: rtl/si_window_tracker_core.sv
// si window tracker: one tick per radio slot in, open/start/end masks out
// depends on swt_pkg, swt_tick_if, swt_mask_if, swt_div and the defines header
//
// usage:
//   in_tick carries frame_number and slot_in_frame, one word per radio slot.
//   out_mask returns one word per tick: window_open_mask, window_start_mask
//   and window_end_mask, one bit per tracked message.
//   cfg_we / cfg_index / cfg_wdata write the window length, slots per frame,
//   message count and the four periods; write only while no tick is in flight.
// operation:
//   a tick is worked message by message through one shared divider that
//   resolves one quotient bit per cycle. an untracked message skips the
//   divider, an open window or a closed window off its slot offset takes one
//   division, a closed window on its offset two. out_mask.valid rises once
//   every message is worked; a new tick is taken only after the last
//   result has moved to the output register. in_tick.ready is high only
//   while the block is idle.
// reset: all windows closed, registers at their defaults, no word pending.
// stall: a finished word waits in the output register; the next tick is
//   already taken and worked, and its result waits until out_mask drains.
`timescale 1ns / 1ps
`include "si_window_tracker_core_defines.svh"

module si_window_tracker_core import swt_pkg::*; #(
  parameter int MAX_MESSAGES = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  swt_tick_if.sink              in_tick,
  swt_mask_if.source            out_mask,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
  localparam logic [IDX_W-1:0]  LAST_MSG  = IDX_W'(MAX_MESSAGES - 1);
  localparam logic [MCNT_W-1:0] MAX_COUNT = MCNT_W'(MAX_MESSAGES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL    = 3'd1;
  localparam logic [2:0] S_RED    = 3'd2;
  localparam logic [2:0] S_MSG    = 3'd3;
  localparam logic [2:0] S_WSTART = 3'd4;
  localparam logic [2:0] S_WX     = 3'd5;
  localparam logic [2:0] S_WF     = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  // configuration registers
  logic [WLEN_W-1:0]   wlen_r;
  logic [NSLOT_W-1:0]  nslot_cfg_r;
  logic [MCNT_W-1:0]   mcount_r;
  logic [PERIOD_W-1:0] period_r [PERIOD_CNT];

  // sequencer
  logic [2:0]              state_r, state_nxt;
  logic [IDX_W-1:0]        msg_r, msg_nxt;
  logic [FRAME_W-1:0]      frame_r, frame_nxt;
  logic [SLOT_W-1:0]       slot_r, slot_nxt;
  logic [NSLOT_W-1:0]      n_r, n_nxt;
  logic [ABS_W-1:0]        now_r, now_nxt;
  logic [DIV_DW-1:0]       qx_r, qx_nxt;
  logic [MAX_MESSAGES-1:0] open_r, open_nxt;
  logic [ABS_W-1:0]        start_r [MAX_MESSAGES];
  logic                    start_we;
  logic [MASK_W-1:0]       open_m_r, open_m_nxt;
  logic [MASK_W-1:0]       start_m_r, start_m_nxt;
  logic [MASK_W-1:0]       end_m_r, end_m_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [MASK_W-1:0] out_open_r, out_open_nxt;
  logic [MASK_W-1:0] out_start_r, out_start_nxt;
  logic [MASK_W-1:0] out_end_r, out_end_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [1:0]          msg2;
  logic [MCNT_W-1:0]   msg_limit;
  logic                tracked;
  logic [ABS_W-1:0]    modulus;
  logic [ABS_W-1:0]    start_rd;
  logic [ABS_W-1:0]    start_mod;
  logic                wrap;
  logic [ABS_W:0]      dist_ext;
  logic [ABS_W-1:0]    slot_dist;
  logic                closing;
  logic [DIV_DW-1:0]   x_off;
  logic [PERIOD_W-1:0] per_sel;
  logic [DIV_SW-1:0]   per_div;
  logic                adv;

  swt_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign msg2      = 2'(msg_r);
  assign msg_limit = (mcount_r > MAX_COUNT) ? MAX_COUNT : mcount_r;
  assign tracked   = MCNT_W'(msg_r) < msg_limit;
  assign modulus   = {n_r, FRAME_W'(0)};
  assign start_rd  = start_r[msg_r];

  // start reduced modulo 1024*n: only the bits above the low ten need the divider
  assign start_mod = {div_rsp.rem[NSLOT_W-1:0], start_rd[FRAME_W-1:0]};
  assign wrap      = now_r < start_mod;
  assign dist_ext  = {1'b0, now_r} + (wrap ? {1'b0, modulus} : '0) - {1'b0, start_mod};
  assign slot_dist = dist_ext[ABS_W-1:0];
  assign closing   = slot_dist > ABS_W'(wlen_r);

  // offset of message n is n*w, n below four
  assign x_off = (msg2[0] ? DIV_DW'(wlen_r) : '0) + (msg2[1] ? DIV_DW'({wlen_r, 1'b0}) : '0);

  assign per_sel = period_r[msg2];
  assign per_div = (per_sel == '0) ? PERIOD_ZERO_AS : DIV_SW'(per_sel);

  always_comb begin
    state_nxt     = state_r;
    msg_nxt       = msg_r;
    frame_nxt     = frame_r;
    slot_nxt      = slot_r;
    n_nxt         = n_r;
    now_nxt       = now_r;
    qx_nxt        = qx_r;
    open_nxt      = open_r;
    start_we      = 1'b0;
    open_m_nxt    = open_m_r;
    start_m_nxt   = start_m_r;
    end_m_nxt     = end_m_r;
    out_valid_nxt = out_valid_r;
    out_open_nxt  = out_open_r;
    out_start_nxt = out_start_r;
    out_end_nxt   = out_end_r;
    div_req       = '0;
    adv           = 1'b0;

    if (out_valid_r && out_mask.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tick.valid) begin
          frame_nxt = in_tick.frame_number;
          slot_nxt  = in_tick.slot_in_frame;
          n_nxt     = (nslot_cfg_r == '0) ? NSLOT_W'(1) : nslot_cfg_r;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        now_nxt   = ABS_W'(frame_r) * ABS_W'(n_r) + ABS_W'(slot_r);
        state_nxt = S_RED;
      end
      S_RED: begin
        // slot index past the frame can push the sum over one modulus at most
        if (now_r >= modulus) begin
          now_nxt = now_r - modulus;
        end
        msg_nxt     = '0;
        open_m_nxt  = '0;
        start_m_nxt = '0;
        end_m_nxt   = '0;
        state_nxt   = S_MSG;
      end
      S_MSG: begin
        if (!tracked) begin
          open_nxt[msg_r] = 1'b0;
          adv             = 1'b1;
        end else if (open_r[msg_r]) begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_DW'(start_rd[ABS_W-1:FRAME_W]);
          div_req.divisor  = DIV_SW'(n_r);
          state_nxt        = S_WSTART;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = x_off;
          div_req.divisor  = DIV_SW'(n_r);
          state_nxt        = S_WX;
        end
      end
      S_WSTART: begin
        if (div_rsp.done) begin
          if (closing) begin
            open_nxt[msg_r] = 1'b0;
            end_m_nxt[msg2] = 1'b1;
          end else begin
            open_m_nxt[msg2] = 1'b1;
          end
          adv = 1'b1;
        end
      end
      S_WX: begin
        if (div_rsp.done) begin
          if (DIV_SW'(slot_r) == div_rsp.rem) begin
            qx_nxt           = div_rsp.quot;
            div_req.start    = 1'b1;
            div_req.dividend = DIV_DW'(frame_r);
            div_req.divisor  = per_div;
            state_nxt        = S_WF;
          end else begin
            adv = 1'b1;
          end
        end
      end
      S_WF: begin
        if (div_rsp.done) begin
          if (DIV_DW'(div_rsp.rem) == qx_r) begin
            open_nxt[msg_r]    = 1'b1;
            start_we           = 1'b1;
            start_m_nxt[msg2]  = 1'b1;
            open_m_nxt[msg2]   = 1'b1;
          end
          adv = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_mask.ready) begin
          out_valid_nxt = 1'b1;
          out_open_nxt  = open_m_r;
          out_start_nxt = start_m_r;
          out_end_nxt   = end_m_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adv) begin
      if (msg_r == LAST_MSG) begin
        state_nxt = S_EMIT;
      end else begin
        msg_nxt   = msg_r + 1'b1;
        state_nxt = S_MSG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      open_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r       <= msg_nxt;
    frame_r     <= frame_nxt;
    slot_r      <= slot_nxt;
    n_r         <= n_nxt;
    now_r       <= now_nxt;
    qx_r        <= qx_nxt;
    open_m_r    <= open_m_nxt;
    start_m_r   <= start_m_nxt;
    end_m_r     <= end_m_nxt;
    out_open_r  <= out_open_nxt;
    out_start_r <= out_start_nxt;
    out_end_r   <= out_end_nxt;
    if (start_we) begin
      start_r[msg_r] <= now_r;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r      <= WINDOW_LEN_RST;
      nslot_cfg_r <= SLOTS_RST;
      mcount_r    <= MSG_COUNT_RST;
      period_r[0] <= PERIOD_RST;
      period_r[1] <= PERIOD_RST;
      period_r[2] <= PERIOD_RST;
      period_r[3] <= PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WINDOW_LEN: wlen_r      <= cfg_wdata[WLEN_W-1:0];
        REG_SLOTS:      nslot_cfg_r <= cfg_wdata[NSLOT_W-1:0];
        REG_MSG_COUNT:  mcount_r    <= cfg_wdata[MCNT_W-1:0];
        REG_PERIOD0:    period_r[0] <= cfg_wdata[PERIOD_W-1:0];
        REG_PERIOD1:    period_r[1] <= cfg_wdata[PERIOD_W-1:0];
        REG_PERIOD2:    period_r[2] <= cfg_wdata[PERIOD_W-1:0];
        REG_PERIOD3:    period_r[3] <= cfg_wdata[PERIOD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tick.ready              = (state_r == S_IDLE);
  assign out_mask.valid             = out_valid_r;
  assign out_mask.window_open_mask  = out_open_r;
  assign out_mask.window_start_mask = out_start_r;
  assign out_mask.window_end_mask   = out_end_r;

  `SWT_ASSERT_NOW(a_start_implies_open, out_valid_r, (out_start_r & ~out_open_r) == '0, "start bit without open bit")
  `SWT_ASSERT_NOW(a_start_end_apart, out_valid_r, (out_start_r & out_end_r) == '0, "window opened and closed in one tick")
  `SWT_ASSERT_NEXT(a_accept_starts_work, in_tick.valid && in_tick.ready, state_r == S_MUL, "accepted tick did not start work")
  `SWT_ASSERT_NOW(a_div_done_waited, div_rsp.done, state_r == S_WSTART || state_r == S_WX || state_r == S_WF, "divider result with nobody waiting")

endmodule

// File: rtl/swt_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on swt_pkg
`timescale 1ns / 1ps

module swt_div import swt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam logic [DIV_CW-1:0] LAST_STEP = DIV_CW'(DIV_DW - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [DIV_SW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_SW-1:0] dsr_r, dsr_nxt;
  logic [DIV_SW:0]   rem_sh;
  logic [DIV_SW:0]   rem_diff;
  logic              fits;

  assign rem_sh   = {rem_r, quo_r[DIV_DW-1]};
  assign fits     = rem_sh >= {1'b0, dsr_r};
  assign rem_diff = rem_sh - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      // dividend bits shift out of quo_r as quotient bits shift in
      rem_nxt = fits ? rem_diff[DIV_SW-1:0] : rem_sh[DIV_SW-1:0];
      quo_nxt = {quo_r[DIV_DW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quo_r;
  assign rsp.rem  = rem_r;

endmodule
